/* hdl/mp4sot_pkg.sv */
// ----------------------------------------------------------------------------
// mp4sot_pkg: shared constants for the MP4 sample-table engine
// Transaction modes, status codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package mp4sot_pkg;

    localparam int DEF_MAX_SAMPLES = 4096;
    localparam int DEF_MAX_RUNS    = 256;
    localparam int DEF_MAX_CHUNKS  = 1024;

    localparam int MODE_W   = 3;
    localparam int IDX_W    = 12;
    localparam int VAL_W    = 64;
    localparam int SIZE_W   = 32;
    localparam int ST_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [MODE_W-1:0] MODE_LOAD_SIZE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_RUN     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD_CHUNK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY_SAMPLE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY_TOTAL  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_IDX_RANGE = 3'd1;
    localparam logic [ST_W-1:0] ST_NO_RUNS   = 3'd2;
    localparam logic [ST_W-1:0] ST_CHUNK_RNG = 3'd3;
    localparam logic [ST_W-1:0] ST_ZERO_PER  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_COUNT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_MODE     = 3'd4;

    localparam logic [1:0] SZ_FULL   = 2'd0;
    localparam logic [1:0] SZ_SIXTEEN = 2'd1;
    localparam logic [1:0] SZ_EIGHT  = 2'd2;
    localparam logic [1:0] SZ_FOUR   = 2'd3;

endpackage

/* hdl/mp4sot_div.sv */
// ----------------------------------------------------------------------------
// mp4sot_div: restoring divider, one quotient bit per cycle
// Divisor must hold steady from start until done.
// ----------------------------------------------------------------------------
module mp4sot_div #(
    parameter int N_W = 12,
    parameter int D_W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient,
    output logic [N_W-1:0] remainder
);

    localparam int C_W = $clog2(N_W + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [C_W-1:0] cnt_reg, cnt_next;
    logic [N_W-1:0] q_reg, q_next;
    logic [D_W:0]   r_reg, r_next;
    logic [D_W:0]   r_shift;

    assign r_shift = {r_reg[D_W-1:0], q_reg[N_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (r_shift >= {1'b0, divisor})
            begin
                r_next = r_shift - {1'b0, divisor};
                q_next = {q_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                r_next = r_shift;
                q_next = {q_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == C_W'(N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = N_W'(r_reg);

endmodule

/* hdl/mp4_sample_offset_table.sv */
// Loads: a size, run or chunk entry is written on acceptance; a 4-bit size pair writes
// its high nibble first, then its low nibble. A sample query walks the runs, runs the
// divide step, then sums the earlier samples in its chunk. A total query takes the
// product with a constant size, the running sum when the count covers the fill, else
// sums each sample. One transaction is in work at a time; input stalls
// until its result is registered. Reset clears fills, sum, registers and control.
// ----------------------------------------------------------------------------
// mp4_sample_offset_table: MP4 sample-table engine
// Appends size, run and chunk-offset entries and answers offset/size queries.
// ----------------------------------------------------------------------------
module mp4_sample_offset_table #(
    parameter int MAX_SAMPLES = mp4sot_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_RUNS    = mp4sot_pkg::DEF_MAX_RUNS,
    parameter int MAX_CHUNKS  = mp4sot_pkg::DEF_MAX_CHUNKS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [mp4sot_pkg::MODE_W-1:0]     mode,
    input  logic [mp4sot_pkg::IDX_W-1:0]      sample_index,
    input  logic [mp4sot_pkg::VAL_W-1:0]      load_value,
    input  logic [mp4sot_pkg::SIZE_W-1:0]     run_samples,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mp4sot_pkg::ST_W-1:0]       status,
    output logic [mp4sot_pkg::VAL_W-1:0]      result_value,
    output logic [mp4sot_pkg::SIZE_W-1:0]     result_size,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mp4sot_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mp4sot_pkg::CFG_DAT_W-1:0]  cfg_data
);

    localparam int IDX_W  = mp4sot_pkg::IDX_W;
    localparam int VAL_W  = mp4sot_pkg::VAL_W;
    localparam int SIZE_W = mp4sot_pkg::SIZE_W;
    localparam int ST_W   = mp4sot_pkg::ST_W;
    localparam int SA_W   = $clog2(MAX_SAMPLES);
    localparam int SF_W   = $clog2(MAX_SAMPLES + 1);
    localparam int RA_W   = $clog2(MAX_RUNS);
    localparam int RF_W   = $clog2(MAX_RUNS + 1);
    localparam int CA_W   = $clog2(MAX_CHUNKS);
    localparam int CF_W   = $clog2(MAX_CHUNKS + 1);
    localparam int CNT_W  = (SF_W > IDX_W) ? SF_W : IDX_W;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_NIB2    = 5'd1;
    localparam logic [4:0] S_TOT_MUL = 5'd2;
    localparam logic [4:0] S_TOT_RD  = 5'd3;
    localparam logic [4:0] S_TOT_ACC = 5'd4;
    localparam logic [4:0] S_RUN_A   = 5'd5;
    localparam logic [4:0] S_RUN_B   = 5'd6;
    localparam logic [4:0] S_RUN_C   = 5'd7;
    localparam logic [4:0] S_RUN_D   = 5'd8;
    localparam logic [4:0] S_DIV_S   = 5'd9;
    localparam logic [4:0] S_DIV_W   = 5'd10;
    localparam logic [4:0] S_OFF_LAT = 5'd11;
    localparam logic [4:0] S_SUM     = 5'd12;
    localparam logic [4:0] S_SUM_ACC = 5'd13;
    localparam logic [4:0] S_SZ_LAT  = 5'd14;
    localparam logic [4:0] S_DONE    = 5'd15;

    // configuration
    logic [12:0]       sample_count_reg;
    logic [8:0]        run_count_reg;
    logic [10:0]       chunk_count_reg;
    logic [SIZE_W-1:0] constant_size_reg;
    logic [1:0]        size_mode_reg;

    // control
    logic [4:0]        state_reg, state_next;
    logic [SF_W-1:0]   size_fill_reg, size_fill_next;
    logic [RF_W-1:0]   run_fill_reg, run_fill_next;
    logic [CF_W-1:0]   chunk_fill_reg, chunk_fill_next;
    logic [VAL_W-1:0]  size_sum_reg, size_sum_next;
    logic              out_valid_reg, out_valid_next;

    // work registers
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [RF_W-1:0]   entry_reg, entry_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SIZE_W-1:0] first_cur_reg, first_cur_next;
    logic [SIZE_W-1:0] per_cur_reg, per_cur_next;
    logic [3:0]        nib_reg, nib_next;
    logic [VAL_W-1:0]  acc_reg, acc_next;
    logic [SIZE_W-1:0] sz_reg, sz_next;
    logic [ST_W-1:0]   st_reg, st_next;
    logic [VAL_W-1:0]  prod_reg;
    logic [SIZE_W-1:0] mul_a, mul_b;

    // output register
    logic [ST_W-1:0]   status_reg;
    logic [VAL_W-1:0]  result_value_reg;
    logic [SIZE_W-1:0] result_size_reg;
    logic              out_load;

    // memories
    logic [SIZE_W-1:0] size_mem  [MAX_SAMPLES];
    logic [SIZE_W-1:0] first_mem [MAX_RUNS];
    logic [SIZE_W-1:0] per_mem   [MAX_RUNS];
    logic [VAL_W-1:0]  off_mem   [MAX_CHUNKS];
    logic              size_we, size_re, run_we, run_re, off_we, off_re;
    logic [SA_W-1:0]   size_waddr, size_raddr;
    logic [SIZE_W-1:0] size_wdata, size_q;
    logic [RA_W-1:0]   run_waddr, run_raddr;
    logic [SIZE_W-1:0] first_q, per_q;
    logic [CA_W-1:0]   off_waddr, off_raddr;
    logic [VAL_W-1:0]  off_q;

    // divider
    logic              div_start, div_done;
    logic [IDX_W-1:0]  div_q, div_r;

    logic [SF_W-1:0]   ns;
    logic [RF_W-1:0]   nr;
    logic [CF_W-1:0]   nc;
    logic              const_mode;
    logic [SIZE_W-1:0] size_eff;
    logic [SIZE_W:0]   chunk1;
    logic [IDX_W-1:0]  fic;

    assign ns = (32'(sample_count_reg) > 32'(MAX_SAMPLES)) ? SF_W'(MAX_SAMPLES)
                                                           : SF_W'(sample_count_reg);
    assign nr = (32'(run_count_reg) > 32'(MAX_RUNS)) ? RF_W'(MAX_RUNS)
                                                     : RF_W'(run_count_reg);
    assign nc = (32'(chunk_count_reg) > 32'(MAX_CHUNKS)) ? CF_W'(MAX_CHUNKS)
                                                         : CF_W'(chunk_count_reg);
    assign const_mode = (size_mode_reg == mp4sot_pkg::SZ_FULL) && (constant_size_reg != '0);
    assign size_eff   = const_mode ? constant_size_reg : size_q;
    assign chunk1     = {1'b0, first_cur_reg} + (SIZE_W + 1)'(div_q);
    assign fic        = idx_reg - pos_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // shared multiplier: track total in idle, run span during the walk
    assign mul_a = (state_reg == S_IDLE) ? constant_size_reg : first_q - first_cur_reg;
    assign mul_b = (state_reg == S_IDLE) ? SIZE_W'(ns) : per_cur_reg;

    mp4sot_div #(
        .N_W (IDX_W),
        .D_W (SIZE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rem_reg),
        .divisor   (per_cur_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        state_next      = state_reg;
        size_fill_next  = size_fill_reg;
        run_fill_next   = run_fill_reg;
        chunk_fill_next = chunk_fill_reg;
        size_sum_next   = size_sum_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        pos_next        = pos_reg;
        entry_next      = entry_reg;
        cnt_next        = cnt_reg;
        first_cur_next  = first_cur_reg;
        per_cur_next    = per_cur_reg;
        nib_next        = nib_reg;
        acc_next        = acc_reg;
        sz_next         = sz_reg;
        st_next         = st_reg;
        size_we         = 1'b0;
        size_waddr      = size_fill_reg[SA_W-1:0];
        size_wdata      = '0;
        size_re         = 1'b0;
        size_raddr      = '0;
        run_we          = 1'b0;
        run_waddr       = run_fill_reg[RA_W-1:0];
        run_re          = 1'b0;
        run_raddr       = entry_reg[RA_W-1:0];
        off_we          = 1'b0;
        off_waddr       = chunk_fill_reg[CA_W-1:0];
        off_re          = 1'b0;
        off_raddr       = '0;
        div_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    acc_next = '0;
                    sz_next  = '0;
                    st_next  = mp4sot_pkg::ST_OK;
                    case (mode)
                        mp4sot_pkg::MODE_LOAD_SIZE:
                        begin
                            case (size_mode_reg)
                                mp4sot_pkg::SZ_FULL:    size_wdata = load_value[31:0];
                                mp4sot_pkg::SZ_SIXTEEN: size_wdata = {16'd0, load_value[15:0]};
                                mp4sot_pkg::SZ_EIGHT:   size_wdata = {24'd0, load_value[7:0]};
                                default:
                                begin
                                    // high nibble first, low nibble next cycle
                                    size_wdata = {28'd0, load_value[7:4]};
                                    nib_next   = load_value[3:0];
                                    state_next = S_NIB2;
                                end
                            endcase
                            if (32'(size_fill_reg) < 32'(MAX_SAMPLES))
                            begin
                                size_we        = 1'b1;
                                size_fill_next = size_fill_reg + 1'b1;
                                size_sum_next  = size_sum_reg + VAL_W'(size_wdata);
                            end
                        end
                        mp4sot_pkg::MODE_LOAD_RUN:
                        begin
                            if (32'(run_fill_reg) < 32'(MAX_RUNS))
                            begin
                                run_we        = 1'b1;
                                run_fill_next = run_fill_reg + 1'b1;
                            end
                        end
                        mp4sot_pkg::MODE_LOAD_CHUNK:
                        begin
                            if (32'(chunk_fill_reg) < 32'(MAX_CHUNKS))
                            begin
                                off_we          = 1'b1;
                                chunk_fill_next = chunk_fill_reg + 1'b1;
                            end
                        end
                        mp4sot_pkg::MODE_QUERY_TOTAL:
                        begin
                            cnt_next = '0;
                            if (const_mode)
                                state_next = S_TOT_MUL;
                            else if (ns >= size_fill_reg)
                            begin
                                acc_next   = size_sum_reg;
                                state_next = S_DONE;
                            end
                            else
                                state_next = S_TOT_RD;
                        end
                        mp4sot_pkg::MODE_QUERY_SAMPLE:
                        begin
                            idx_next   = sample_index;
                            rem_next   = sample_index;
                            entry_next = '0;
                            if (32'(sample_index) >= 32'(ns))
                            begin
                                st_next    = mp4sot_pkg::ST_IDX_RANGE;
                                state_next = S_DONE;
                            end
                            else if (nr == '0)
                            begin
                                st_next    = mp4sot_pkg::ST_NO_RUNS;
                                state_next = S_DONE;
                            end
                            else
                                state_next = S_RUN_A;
                        end
                        default:
                        begin
                            // undefined modes: drop
                        end
                    endcase
                end
            end
            S_NIB2:
            begin
                size_wdata = {28'd0, nib_reg};
                if (32'(size_fill_reg) < 32'(MAX_SAMPLES))
                begin
                    size_we        = 1'b1;
                    size_fill_next = size_fill_reg + 1'b1;
                    size_sum_next  = size_sum_reg + VAL_W'(size_wdata);
                end
                state_next = S_IDLE;
            end
            S_TOT_MUL:
            begin
                acc_next   = prod_reg;
                state_next = S_DONE;
            end
            S_TOT_RD:
            begin
                if (cnt_reg < CNT_W'(ns))
                begin
                    size_re    = 1'b1;
                    size_raddr = cnt_reg[SA_W-1:0];
                    state_next = S_TOT_ACC;
                end
                else
                    state_next = S_DONE;
            end
            S_TOT_ACC:
            begin
                acc_next   = acc_reg + VAL_W'(size_q);
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_TOT_RD;
            end
            S_RUN_A:
            begin
                run_re     = 1'b1;
                state_next = S_RUN_B;
            end
            S_RUN_B:
            begin
                first_cur_next = first_q;
                per_cur_next   = per_q;
                if (entry_reg + 1'b1 < nr)
                begin
                    run_re     = 1'b1;
                    run_raddr  = RA_W'(entry_reg + 1'b1);
                    state_next = S_RUN_C;
                end
                else
                    state_next = S_DIV_S;
            end
            S_RUN_C:
            begin
                state_next = S_RUN_D;
            end
            S_RUN_D:
            begin
                if (VAL_W'(rem_reg) < prod_reg)
                    state_next = S_DIV_S;
                else
                begin
                    rem_next   = rem_reg - prod_reg[IDX_W-1:0];
                    entry_next = entry_reg + 1'b1;
                    state_next = S_RUN_A;
                end
            end
            S_DIV_S:
            begin
                if (per_cur_reg == '0)
                begin
                    st_next    = mp4sot_pkg::ST_ZERO_PER;
                    state_next = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV_W;
                end
            end
            S_DIV_W:
            begin
                if (div_done)
                begin
                    pos_next = div_r;
                    if ((chunk1 == '0) || ((chunk1 - 1'b1) >= (SIZE_W + 1)'(nc)))
                    begin
                        st_next    = mp4sot_pkg::ST_CHUNK_RNG;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        off_re     = 1'b1;
                        off_raddr  = CA_W'(chunk1 - 1'b1);
                        state_next = S_OFF_LAT;
                    end
                end
            end
            S_OFF_LAT:
            begin
                acc_next   = off_q;
                cnt_next   = '0;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                size_re = 1'b1;
                if (cnt_reg < CNT_W'(pos_reg))
                begin
                    size_raddr = SA_W'(CNT_W'(fic) + cnt_reg);
                    state_next = S_SUM_ACC;
                end
                else
                begin
                    size_raddr = SA_W'(idx_reg);
                    state_next = S_SZ_LAT;
                end
            end
            S_SUM_ACC:
            begin
                acc_next   = acc_reg + VAL_W'(size_eff);
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_SUM;
            end
            S_SZ_LAT:
            begin
                sz_next    = size_eff;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register frees up
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && out_stall) || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            size_fill_reg     <= '0;
            run_fill_reg      <= '0;
            chunk_fill_reg    <= '0;
            size_sum_reg      <= '0;
            out_valid_reg     <= 1'b0;
            sample_count_reg  <= '0;
            run_count_reg     <= '0;
            chunk_count_reg   <= '0;
            constant_size_reg <= '0;
            size_mode_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            size_fill_reg  <= size_fill_next;
            run_fill_reg   <= run_fill_next;
            chunk_fill_reg <= chunk_fill_next;
            size_sum_reg   <= size_sum_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mp4sot_pkg::CFG_SAMPLE_COUNT:  sample_count_reg  <= cfg_data[12:0];
                    mp4sot_pkg::CFG_RUN_COUNT:     run_count_reg     <= cfg_data[8:0];
                    mp4sot_pkg::CFG_CHUNK_COUNT:   chunk_count_reg   <= cfg_data[10:0];
                    mp4sot_pkg::CFG_CONSTANT_SIZE: constant_size_reg <= cfg_data;
                    mp4sot_pkg::CFG_SIZE_MODE:     size_mode_reg     <= cfg_data[1:0];
                    default:
                    begin
                        // unknown index: drop
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        rem_reg       <= rem_next;
        pos_reg       <= pos_next;
        entry_reg     <= entry_next;
        cnt_reg       <= cnt_next;
        first_cur_reg <= first_cur_next;
        per_cur_reg   <= per_cur_next;
        nib_reg       <= nib_next;
        acc_reg       <= acc_next;
        sz_reg        <= sz_next;
        st_reg        <= st_next;
        prod_reg      <= VAL_W'(mul_a) * VAL_W'(mul_b);
        if (out_load)
        begin
            status_reg       <= st_reg;
            result_value_reg <= acc_reg;
            result_size_reg  <= sz_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
            size_mem[size_waddr] <= size_wdata;
        if (size_re)
            size_q <= size_mem[size_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (run_we)
        begin
            first_mem[run_waddr] <= load_value[31:0];
            per_mem[run_waddr]   <= run_samples;
        end
        if (run_re)
        begin
            first_q <= first_mem[run_raddr];
            per_q   <= per_mem[run_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (off_we)
            off_mem[off_waddr] <= load_value;
        if (off_re)
            off_q <= off_mem[off_raddr];
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_value = result_value_reg;
    assign result_size  = result_size_reg;

endmodule

/* hdl/mp4sot_checker.sv */
// ----------------------------------------------------------------------------
// mp4sot_assert: port-level assertions for the sample-table engine
// Bound to the top level; watches handshakes and result fields.
// ----------------------------------------------------------------------------
module mp4sot_assert (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic [mp4sot_pkg::MODE_W-1:0]     mode,
    input logic [mp4sot_pkg::IDX_W-1:0]      sample_index,
    input logic [mp4sot_pkg::VAL_W-1:0]      load_value,
    input logic [mp4sot_pkg::SIZE_W-1:0]     run_samples,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [mp4sot_pkg::ST_W-1:0]       status,
    input logic [mp4sot_pkg::VAL_W-1:0]      result_value,
    input logic [mp4sot_pkg::SIZE_W-1:0]     result_size,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [mp4sot_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [mp4sot_pkg::CFG_DAT_W-1:0]  cfg_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // errors carry zero payload
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != mp4sot_pkg::ST_OK) |-> (result_value == '0) && (result_size == '0))
        else $error("error result with nonzero payload");

    // a query occupies the engine for at least the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && ((mode == mp4sot_pkg::MODE_QUERY_SAMPLE) ||
        (mode == mp4sot_pkg::MODE_QUERY_TOTAL)) |=> in_stall)
        else $error("query accepted without going busy");

    // no sized result shows on the first cycle out of reset
    a_total_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == mp4sot_pkg::ST_OK) && (result_size != '0) |->
        $past(rst_n))
        else $error("result shown straight out of reset");

endmodule

bind mp4_sample_offset_table mp4sot_assert u_mp4sot_assert (.*);
